FILE: hdl/gqet_pkg.sv
package gqet_pkg;

    localparam int LIM_W = 16;
    localparam int DIV_NUM_W = 24;
    localparam int COLOR_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [7:0] COLOR_SCALE = 8'd254;
    localparam logic [8:0] COLOR_SPAN = 9'd256;
    localparam logic [LIM_W-1:0] LIM_RESET = 16'd256;

    localparam logic [1:0] SRC_COORD = 2'd0;
    localparam logic [1:0] SRC_NEG = 2'd1;
    localparam logic [1:0] SRC_CONST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MODES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CONST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAD_COEF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_COEF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_COEF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_MODE = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ITER,
        ST_DIV_GO,
        ST_DIV_RUN,
        ST_OUT
    } t_state;

endpackage

FILE: hdl/gqet_cell.sv
module gqet_cell #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int SHIFT = 28
) (
    input  logic                         i_clk,
    input  logic signed [AW-1:0]         i_a,
    input  logic signed [BW-1:0]         i_b,
    output logic signed [AW+BW-SHIFT-1:0] o_p
);

    logic signed [AW+BW-1:0] n_prod;
    logic signed [AW+BW-SHIFT-1:0] r_p;

    always_comb begin
        n_prod = $signed({{BW{i_a[AW-1]}}, i_a}) * $signed({{AW{i_b[BW-1]}}, i_b});
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_prod[AW+BW-1:SHIFT];
    end

    assign o_p = r_p;

endmodule

FILE: hdl/gqet_div.sv
module gqet_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gqet_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [gqet_pkg::LIM_W-1:0]     i_den,
    output logic                          o_done,
    output logic [gqet_pkg::DIV_NUM_W-1:0] o_quot
);

    localparam int NW = gqet_pkg::DIV_NUM_W;
    localparam int DW = gqet_pkg::LIM_W;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_q;
    logic [DW:0]   n_trial;
    logic          n_ge;
    logic [DW:0]   n_diff;

    always_comb begin
        n_trial = {r_rem, r_q[NW-1]};
        n_ge = n_trial >= {1'b0, r_den};
        n_diff = n_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_q <= i_num;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[DW-1:0] : n_trial[DW-1:0];
            r_q <= {r_q[NW-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: hdl/general_quadratic_escape_time.sv
// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_stall      i_coord_x, i_coord_y
// output    out        o_out_valid / i_out_stall    o_color_index, o_iter_count
// config    in         i_cfg_we                     i_cfg_index, i_cfg_data
// One request steps through each iteration of the map (squaring cells, difference,
// coefficient cells, sum), then through the colour divider, with load before and hand-off after.
// The iteration count runs up to iter_limit.
// Reset is synchronous and active low; it empties the block and restores the registers.
// A stalled result holds in the output register while the next request is taken.
module general_quadratic_escape_time #(
    parameter int COORD_WIDTH = 32,
    parameter int ITER_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [COORD_WIDTH-1:0]       i_coord_x,
    input  logic signed [COORD_WIDTH-1:0]       i_coord_y,
    input  logic                                i_cfg_we,
    input  logic [gqet_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gqet_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [gqet_pkg::COLOR_W-1:0]        o_color_index,
    output logic [ITER_WIDTH-1:0]               o_iter_count
);

    localparam int W = COORD_WIDTH;
    localparam int F = W - 4;
    localparam int SQW = W + 4;
    localparam int TW = W + 5;
    localparam int PW = W + TW - F;
    localparam int SW = PW + 3;
    localparam int LW = gqet_pkg::LIM_W;
    localparam int NW = gqet_pkg::DIV_NUM_W;
    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [SQW:0] FOUR = (SQW+1)'(4) <<< F;

    function automatic logic signed [W-1:0] pick(input logic [1:0] mode,
                                                 input logic signed [W-1:0] coord,
                                                 input logic signed [W-1:0] cst);
        logic signed [W-1:0] r;
        case (mode)
            gqet_pkg::SRC_NEG: begin
                r = (coord == CMIN) ? CMAX : -coord;
            end
            gqet_pkg::SRC_CONST: begin
                r = cst;
            end
            default: begin
                r = coord;
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [W-1:0] half(input logic [63:0] v, input logic hi);
        logic [31:0]   h;
        logic [W+31:0] e;
        h = hi ? v[63:32] : v[31:0];
        e = {{W{1'b0}}, h};
        return e[W-1:0];
    endfunction

    logic [15:0]  r_modes;
    logic [63:0]  r_start_c;
    logic [63:0]  r_quad_c;
    logic [63:0]  r_lin_c;
    logic [63:0]  r_add_c;
    logic [LW-1:0] r_limit;
    logic         r_vec;

    gqet_pkg::t_state r_state;
    gqet_pkg::t_state n_state;
    logic [1:0]   r_ph;
    logic [1:0]   n_ph;
    logic [LW-1:0] r_n;

    logic signed [W-1:0] r_zr, r_zi, r_ar, r_ai, r_cr, r_ci, r_er, r_ei;
    logic signed [TW-1:0] r_d;

    logic signed [SQW-1:0] sq_r, sq_i;
    logic signed [TW-1:0]  t_p;
    logic signed [PW-1:0]  p_ard, p_ait, p_art, p_aid;
    logic signed [SQW-1:0] p_crzr, p_cizi, p_crzi, p_cizr;
    logic signed [SW-1:0]  n_sum_r, n_sum_i;
    logic signed [W-1:0]   n_zr, n_zi;
    logic signed [SQW:0]   n_mag;
    logic                  n_go;

    logic          div_start;
    logic          div_done;
    logic [NW-1:0] div_q;
    logic [NW-1:0] n_num;
    logic [LW-1:0] n_den;

    logic         r_out_valid;
    logic [gqet_pkg::COLOR_W-1:0] r_color;
    logic [LW-1:0] r_count;
    logic         n_load_out;
    logic         n_accept;
    logic [gqet_pkg::COLOR_W-1:0] n_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modes <= '0;
            r_start_c <= '0;
            r_quad_c <= '0;
            r_lin_c <= '0;
            r_add_c <= '0;
            r_limit <= gqet_pkg::LIM_RESET;
            r_vec <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gqet_pkg::CFG_SOURCE_MODES: r_modes <= i_cfg_data[15:0];
                gqet_pkg::CFG_START_CONST: r_start_c <= i_cfg_data;
                gqet_pkg::CFG_QUAD_COEF: r_quad_c <= i_cfg_data;
                gqet_pkg::CFG_LIN_COEF: r_lin_c <= i_cfg_data;
                gqet_pkg::CFG_ADD_COEF: r_add_c <= i_cfg_data;
                gqet_pkg::CFG_ITER_LIMIT: r_limit <= i_cfg_data[LW-1:0];
                gqet_pkg::CFG_VECTOR_MODE: r_vec <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    gqet_cell #(.AW(W), .BW(W), .SHIFT(F)) u_sq_r (
        .i_clk(i_clk), .i_a(r_zr), .i_b(r_zr), .o_p(sq_r));
    gqet_cell #(.AW(W), .BW(W), .SHIFT(F)) u_sq_i (
        .i_clk(i_clk), .i_a(r_zi), .i_b(r_zi), .o_p(sq_i));
    gqet_cell #(.AW(W), .BW(W), .SHIFT(F-1)) u_cross (
        .i_clk(i_clk), .i_a(r_zr), .i_b(r_zi), .o_p(t_p));
    gqet_cell #(.AW(W), .BW(TW), .SHIFT(F)) u_ard (
        .i_clk(i_clk), .i_a(r_ar), .i_b(r_d), .o_p(p_ard));
    gqet_cell #(.AW(W), .BW(TW), .SHIFT(F)) u_ait (
        .i_clk(i_clk), .i_a(r_ai), .i_b(t_p), .o_p(p_ait));
    gqet_cell #(.AW(W), .BW(TW), .SHIFT(F)) u_art (
        .i_clk(i_clk), .i_a(r_ar), .i_b(t_p), .o_p(p_art));
    gqet_cell #(.AW(W), .BW(TW), .SHIFT(F)) u_aid (
        .i_clk(i_clk), .i_a(r_ai), .i_b(r_d), .o_p(p_aid));
    gqet_cell #(.AW(W), .BW(W), .SHIFT(F)) u_crzr (
        .i_clk(i_clk), .i_a(r_cr), .i_b(r_zr), .o_p(p_crzr));
    gqet_cell #(.AW(W), .BW(W), .SHIFT(F)) u_cizi (
        .i_clk(i_clk), .i_a(r_ci), .i_b(r_zi), .o_p(p_cizi));
    gqet_cell #(.AW(W), .BW(W), .SHIFT(F)) u_crzi (
        .i_clk(i_clk), .i_a(r_cr), .i_b(r_zi), .o_p(p_crzi));
    gqet_cell #(.AW(W), .BW(W), .SHIFT(F)) u_cizr (
        .i_clk(i_clk), .i_a(r_ci), .i_b(r_zr), .o_p(p_cizr));

    always_comb begin
        n_sum_r = SW'(p_ard) - SW'(p_ait) + SW'(p_crzr) - SW'(p_cizi) + SW'(r_er);
        n_sum_i = SW'(p_art) + SW'(p_aid) + SW'(p_crzi) + SW'(p_cizr) + SW'(r_ei);
        if (n_sum_r > SW'(CMAX)) begin
            n_zr = CMAX;
        end else if (n_sum_r < SW'(CMIN)) begin
            n_zr = CMIN;
        end else begin
            n_zr = n_sum_r[W-1:0];
        end
        if (n_sum_i > SW'(CMAX)) begin
            n_zi = CMAX;
        end else if (n_sum_i < SW'(CMIN)) begin
            n_zi = CMIN;
        end else begin
            n_zi = n_sum_i[W-1:0];
        end
        n_mag = (SQW+1)'(sq_r) + (SQW+1)'(sq_i);
        n_go = (n_mag < FOUR) && (r_n < r_limit);
        n_num = NW'(gqet_pkg::COLOR_SCALE * r_n);
        n_den = (r_limit < LW'(2)) ? LW'(1) : r_limit - LW'(1);
        if (r_n < r_limit) begin
            n_color = gqet_pkg::COLOR_W'(div_q + NW'(1));
            if (r_vec && r_zr == '0 && r_zi[W-1]) begin
                n_color = gqet_pkg::COLOR_W'(gqet_pkg::COLOR_SPAN -
                                             9'(div_q[gqet_pkg::COLOR_W-1:0] + 8'd1));
            end
        end else begin
            n_color = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ph = r_ph;
        n_accept = 1'b0;
        n_load_out = 1'b0;
        div_start = 1'b0;
        o_in_stall = r_state != gqet_pkg::ST_IDLE;
        case (r_state)
            gqet_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_accept = 1'b1;
                    n_state = gqet_pkg::ST_ITER;
                    n_ph = 2'd0;
                end
            end
            gqet_pkg::ST_ITER: begin
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd3 && !n_go) begin
                    n_state = gqet_pkg::ST_DIV_GO;
                end
            end
            gqet_pkg::ST_DIV_GO: begin
                div_start = 1'b1;
                n_state = gqet_pkg::ST_DIV_RUN;
            end
            gqet_pkg::ST_DIV_RUN: begin
                if (div_done) begin
                    n_state = gqet_pkg::ST_OUT;
                end
            end
            gqet_pkg::ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_load_out = 1'b1;
                    n_state = gqet_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gqet_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gqet_pkg::ST_IDLE;
            r_ph <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph <= n_ph;
            if (n_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_zr <= pick(r_modes[1:0], i_coord_x, half(r_start_c, 1'b0));
            r_zi <= pick(r_modes[3:2], i_coord_y, half(r_start_c, 1'b1));
            r_ar <= pick(r_modes[5:4], i_coord_x, half(r_quad_c, 1'b0));
            r_ai <= pick(r_modes[7:6], i_coord_y, half(r_quad_c, 1'b1));
            r_cr <= pick(r_modes[9:8], i_coord_x, half(r_lin_c, 1'b0));
            r_ci <= pick(r_modes[11:10], i_coord_y, half(r_lin_c, 1'b1));
            r_er <= pick(r_modes[13:12], i_coord_x, half(r_add_c, 1'b0));
            r_ei <= pick(r_modes[15:14], i_coord_y, half(r_add_c, 1'b1));
            r_n <= '0;
        end else if (r_state == gqet_pkg::ST_ITER) begin
            if (r_ph == 2'd1) begin
                r_d <= TW'(sq_r) - TW'(sq_i);
            end
            if (r_ph == 2'd3) begin
                r_zr <= n_zr;
                r_zi <= n_zi;
                if (n_go) begin
                    r_n <= r_n + LW'(1);
                end
            end
        end
        if (n_load_out) begin
            r_color <= n_color;
            r_count <= r_n;
        end
    end

    gqet_div u_div (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num(n_num),
        .i_den(n_den),
        .o_done(div_done),
        .o_quot(div_q)
    );

    assign o_out_valid = r_out_valid;
    assign o_color_index = r_color;
    assign o_iter_count = ITER_WIDTH'(r_count);

endmodule

FILE: tb/tb_general_quadratic_escape_time.sv
`timescale 1ns / 100ps

module tb_general_quadratic_escape_time;

    localparam int CW = 32;
    localparam int IW = 16;
    localparam int FB = CW - 4;

    typedef struct {
        logic [gqet_pkg::COLOR_W-1:0] color;
        logic [IW-1:0]                iters;
    } t_pixel_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic signed [CW-1:0]            i_coord_x = '0;
    logic signed [CW-1:0]            i_coord_y = '0;
    logic                            i_cfg_we = 1'b0;
    logic [gqet_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [gqet_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [gqet_pkg::COLOR_W-1:0]    o_color_index;
    logic [IW-1:0]                   o_iter_count;

    logic [15:0] cur_modes = 16'd0;
    logic [63:0] cur_start = '0;
    logic [63:0] cur_quad = '0;
    logic [63:0] cur_lin = '0;
    logic [63:0] cur_add = '0;
    logic [15:0] cur_limit = gqet_pkg::LIM_RESET;
    logic        cur_vector = 1'b0;

    t_pixel_result pending_pixels[$];
    int            mismatches = 0;
    bit            hold_pending = 0;

    general_quadratic_escape_time #(.COORD_WIDTH(CW), .ITER_WIDTH(IW)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_color_index(o_color_index), .o_iter_count(o_iter_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("general_quadratic_escape_time: mismatch");
        $finish;
    end

    function automatic longint sat_coord(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint mul_floor(longint a, longint b, int s);
        logic signed [127:0] pa, pb, p;
        pa = a;
        pb = b;
        p = (pa * pb) >>> s;
        if (p > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (p < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return longint'(p);
    endfunction

    function automatic longint select_source(int slot, longint coord, logic [63:0] pk, bit hi);
        logic [1:0]  m;
        logic [31:0] c;
        m = cur_modes[2*slot +: 2];
        c = hi ? pk[63:32] : pk[31:0];
        if (m == gqet_pkg::SRC_CONST) return longint'(signed'(c));
        if (m == gqet_pkg::SRC_NEG) return sat_coord(-coord);
        return coord;
    endfunction

    function automatic t_pixel_result escape_pixel(logic signed [CW-1:0] x,
                                                   logic signed [CW-1:0] y);
        longint zr, zi, ar, ai, cr, ci, er, ei;
        longint zr2, zi2, t, d, nr, ni, n, lim, dv, c;
        t_pixel_result r;
        zr = select_source(0, x, cur_start, 0);
        zi = select_source(1, y, cur_start, 1);
        ar = select_source(2, x, cur_quad, 0);
        ai = select_source(3, y, cur_quad, 1);
        cr = select_source(4, x, cur_lin, 0);
        ci = select_source(5, y, cur_lin, 1);
        er = select_source(6, x, cur_add, 0);
        ei = select_source(7, y, cur_add, 1);
        zr2 = 0;
        zi2 = 0;
        n = -1;
        lim = cur_limit;
        c = 0;
        while (zr2 + zi2 < (64'sd4 <<< FB) && n < lim) begin
            zr2 = mul_floor(zr, zr, FB);
            zi2 = mul_floor(zi, zi, FB);
            t = mul_floor(zr, zi, FB - 1);
            d = zr2 - zi2;
            nr = mul_floor(ar, d, FB) - mul_floor(ai, t, FB) + mul_floor(cr, zr, FB)
                 - mul_floor(ci, zi, FB) + er;
            ni = mul_floor(ar, t, FB) + mul_floor(ai, d, FB) + mul_floor(cr, zi, FB)
                 + mul_floor(ci, zr, FB) + ei;
            zr = sat_coord(nr);
            zi = sat_coord(ni);
            n++;
        end
        if (n < lim) begin
            dv = (lim - 1 < 1) ? 1 : lim - 1;
            c = 254 * n / dv + 1;
            if (cur_vector && zr == 0 && zi < 0) c = 256 - c;
        end
        r.color = c[gqet_pkg::COLOR_W-1:0];
        r.iters = n[IW-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint want, longint got);
        $display("%s: expected %0d, got %0d", what, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected result colour", -1, o_color_index);
            end else begin
                t_pixel_result e;
                e = pending_pixels.pop_front();
                if (o_color_index !== e.color)
                    report_mismatch("colour index", e.color, o_color_index);
                if (o_iter_count !== e.iters)
                    report_mismatch("iteration count", e.iters, o_iter_count);
            end
        end
    end

    initial begin
        int r, len;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 0;
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    i_out_stall <= 1'b0;
                    repeat (100) @(posedge i_clk);
                end else begin
                    len = (r < 13) ? $urandom_range(20, 80) : $urandom_range(1, 4);
                    i_out_stall <= ($urandom_range(0, 2) == 0);
                    repeat (len - 1) @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_pixel(logic signed [CW-1:0] x, logic signed [CW-1:0] y, bit no_gap = 0);
        int r, gap;
        i_in_valid <= 1'b1;
        i_coord_x <= x;
        i_coord_y <= y;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_pixels.push_back(escape_pixel(x, y));
        r = $urandom_range(0, 99);
        gap = no_gap ? 0 : (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_pixels();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [gqet_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            gqet_pkg::CFG_SOURCE_MODES: cur_modes = data[15:0];
            gqet_pkg::CFG_START_CONST:  cur_start = data;
            gqet_pkg::CFG_QUAD_COEF:    cur_quad = data;
            gqet_pkg::CFG_LIN_COEF:     cur_lin = data;
            gqet_pkg::CFG_ADD_COEF:     cur_add = data;
            gqet_pkg::CFG_ITER_LIMIT:   cur_limit = data[15:0];
            gqet_pkg::CFG_VECTOR_MODE:  cur_vector = data[0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [15:0] modes, logic [63:0] s, logic [63:0] q,
                             logic [63:0] l, logic [63:0] a, logic [15:0] lim, bit vec);
        drain_pixels();
        write_reg(gqet_pkg::CFG_SOURCE_MODES, modes);
        write_reg(gqet_pkg::CFG_START_CONST, s);
        write_reg(gqet_pkg::CFG_QUAD_COEF, q);
        write_reg(gqet_pkg::CFG_LIN_COEF, l);
        write_reg(gqet_pkg::CFG_ADD_COEF, a);
        write_reg(gqet_pkg::CFG_ITER_LIMIT, lim);
        write_reg(gqet_pkg::CFG_VECTOR_MODE, vec);
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, 1342177280) - 671088640;
    endfunction

    function automatic logic [63:0] rand_const_pair();
        if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
        return {rand_coord(), rand_coord()};
    endfunction

    task automatic test_default_extremes();
        send_pixel(32'sd0, 32'sd0);
        send_pixel(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pixel(32'h8000_0000, 32'h8000_0000);
        send_pixel(32'h7FFF_FFFF, 32'h8000_0000);
        send_pixel(32'h1000_0000, 32'hF000_0000);
        send_pixel(32'h0400_0000, 32'h0200_0000);
    endtask

    task automatic test_source_selectors();
        configure(16'h5555, 64'h1000_0000_F000_0000, '0, '0, '0, 16'd40, 1'b0);
        send_pixel(32'h8000_0000, 32'h8000_0000);
        send_pixel(32'h0800_0000, 32'hF800_0000);
        configure(16'hFFFF, 64'h1000_0000_F000_0000, '0, '0, '0, 16'd40, 1'b0);
        send_pixel(32'h0400_0000, 32'h0400_0000);
        configure(16'hAAAA, 64'h0800_0000_0800_0000, 64'h0000_0000_1000_0000,
                  '0, 64'h0400_0000_F800_0000, 16'd40, 1'b0);
        send_pixel(32'h1234_5678, 32'h8765_4321);
        configure(16'h1B6C, 64'h0200_0000_0300_0000, 64'hFF00_0000_1000_0000,
                  64'h0800_0000_F000_0000, 64'h0400_0000_0100_0000, 16'd40, 1'b0);
        send_pixel(32'h0800_0000, 32'h8000_0000);
    endtask

    task automatic test_iteration_limits();
        configure(16'h0000, '0, '0, '0, '0, 16'd2, 1'b0);
        send_pixel(32'sd0, 32'sd0);
        send_pixel(32'h3000_0000, 32'h0000_0000);
        configure(16'h0000, '0, '0, '0, '0, 16'd1, 1'b0);
        send_pixel(32'h3000_0000, 32'h3000_0000);
        send_pixel(32'sd0, 32'sd0);
        configure(16'h0000, '0, '0, '0, '0, 16'd0, 1'b0);
        send_pixel(32'h3000_0000, 32'h3000_0000);
        configure(16'h0000, '0, '0, '0, '0, 16'hFFFF, 1'b0);
        send_pixel(32'h3000_0000, 32'h1000_0000);
        send_pixel(32'sd0, 32'sd0);
    endtask

    task automatic test_vector_mirror();
        configure(16'hAAAA, '0, '0, '0, 64'hD000_0000_0000_0000, 16'd20, 1'b1);
        send_pixel(32'h0100_0000, 32'h0200_0000);
        configure(16'hAAAA, '0, '0, '0, 64'h3000_0000_0000_0000, 16'd20, 1'b1);
        send_pixel(32'sd0, 32'sd0);
        configure(16'hAAAA, '0, '0, '0, 64'hD000_0000_0000_0000, 16'd20, 1'b0);
        send_pixel(32'sd0, 32'sd0);
    endtask

    task automatic test_stalled_output();
        configure(16'h0000, '0, '0, '0, '0, 16'd8, 1'b0);
        hold_pending = 1;
        repeat (20) send_pixel(rand_coord(), rand_coord(), 1);
    endtask

    task automatic test_sender_pause();
        repeat (5) send_pixel(rand_coord(), rand_coord());
        drain_pixels();
        repeat (5) send_pixel(rand_coord(), rand_coord());
    endtask

    task automatic test_random_phases();
        logic [15:0] lim;
        logic [15:0] modes;
        for (int phase = 0; phase < 10; phase++) begin
            modes = (phase % 3 == 0) ? 16'h0000 : 16'($urandom);
            lim = (phase == 9) ? 16'd2 : 16'($urandom_range(2, 64));
            configure(modes, rand_const_pair(), rand_const_pair(), rand_const_pair(),
                      rand_const_pair(), lim, $urandom_range(0, 1));
            repeat (56) send_pixel(rand_coord(), rand_coord());
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_extremes();
        test_source_selectors();
        test_iteration_limits();
        test_vector_mirror();
        test_stalled_output();
        test_sender_pause();
        test_random_phases();
        drain_pixels();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0)
            $display("general_quadratic_escape_time: match");
        else
            $display("general_quadratic_escape_time: mismatch");
        $finish;
    end

endmodule
